FILE: rtl/core/hcc_pkg.sv
package hcc_pkg;

  localparam int unsigned VMASK_W    = 64;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CIDX_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES_IN_USE     = 1'b1;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic [CNT_W-1:0] EDGES_IN_USE_RST = 7'd64;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic eval;
    logic new_pass;
    logic emit;
    logic emit_empty;
  } hcc_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic k_last;
    logic grew;
    logic out_free;
  } hcc_sts_t;

endpackage

FILE: rtl/core/hcc_ctrl.sv
module hcc_ctrl
  import hcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     func_i,
  output logic     in_stall_o,
  input  hcc_sts_t sts_i,
  output hcc_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_EVAL  = 7'b0001000,
    ST_PEND  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_EMPTY = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_COMPUTE) begin
            cmd_o.start = 1'b1;
            state_d     = ST_CHECK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        state_d = sts_i.rem_zero ? ST_EMPTY : ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.k_last ? ST_PEND : ST_RD;
      end
      ST_PEND: begin
        if (sts_i.grew) begin
          cmd_o.new_pass = 1'b1;
          state_d        = ST_RD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.rem_zero ? ST_IDLE : ST_RD;
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hcc_dp.sv
module hcc_dp
  import hcc_pkg::*;
#(
  parameter int unsigned MAX_EDGES = 64,
  parameter int unsigned MAX_VERTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SLOT_W-1:0]     edge_index_i,
  input  logic [VMASK_W-1:0]    vertex_mask_i,
  input  logic                  edge_valid_i,
  input  logic [WEIGHT_W-1:0]   edge_weight_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [VMASK_W-1:0]    component_mask_o,
  output logic [CIDX_W-1:0]     component_index_o,
  output logic [CNT_W-1:0]      component_count_o,
  output logic                  empty_res_o,
  output logic                  last_o,
  input  hcc_cmd_t              cmd_i,
  output hcc_sts_t              sts_o
);

  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam logic [CNT_W-1:0] MaxEdgesC = CNT_W'(MAX_EDGES);

  logic [WEIGHT_W-1:0]  thr_q;
  logic [CNT_W-1:0]     in_use_q;
  logic [CNT_W-1:0]     scan;

  logic [MAX_VERTS-1:0] mem_q [MAX_EDGES];
  logic [MAX_VERTS-1:0] rd_q;
  logic [MAX_EDGES-1:0] active_q;
  logic [MAX_EDGES-1:0] scan_mask;

  logic [MAX_EDGES-1:0] rem_q, rem_d;
  logic [MAX_VERTS-1:0] acc_q, acc_d;
  logic [EIDX_W-1:0]    k_q, k_d;
  logic                 started_q, started_d;
  logic                 grew_q, grew_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                 out_valid_q;
  logic [VMASK_W-1:0]   out_mask_q;
  logic [CIDX_W-1:0]    out_idx_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_empty_q;
  logic                 out_last_q;

  logic                 slot_ok;
  logic                 rem_zero;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      in_use_q <= EDGES_IN_USE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WEIGHT_THRESHOLD: thr_q    <= cfg_data_i[WEIGHT_W-1:0];
        CFG_EDGES_IN_USE:     in_use_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign scan = (in_use_q > MaxEdgesC) ? MaxEdgesC : in_use_q;

  always_comb begin
    for (int unsigned i = 0; i < MAX_EDGES; i++) begin
      scan_mask[i] = (CNT_W'(i) < scan);
    end
  end

  assign slot_ok = (CNT_W'(edge_index_i) < MaxEdgesC);

  // edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      mem_q[edge_index_i[EIDX_W-1:0]] <= vertex_mask_i[MAX_VERTS-1:0];
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.load && slot_ok) begin
      active_q[edge_index_i[EIDX_W-1:0]] <= edge_valid_i && (edge_weight_i > thr_q);
    end
  end

  // component search
  always_comb begin
    rem_d     = rem_q;
    acc_d     = acc_q;
    k_d       = k_q;
    started_d = started_q;
    grew_d    = grew_q;
    count_d   = count_q;
    if (cmd_i.start) begin
      rem_d     = active_q & scan_mask;
      acc_d     = '0;
      k_d       = '0;
      started_d = 1'b0;
      grew_d    = 1'b0;
      count_d   = '0;
    end
    if (cmd_i.eval) begin
      k_d = k_q + EIDX_W'(1);
      if (rem_q[k_q]) begin
        if (!started_q) begin
          acc_d         = rd_q;
          started_d     = 1'b1;
          rem_d[k_q]    = 1'b0;
        end else if ((rd_q & acc_q) != '0) begin
          acc_d      = acc_q | rd_q;
          rem_d[k_q] = 1'b0;
          if ((rd_q & ~acc_q) != '0) begin
            grew_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.new_pass) begin
      k_d    = '0;
      grew_d = 1'b0;
    end
    if (cmd_i.emit) begin
      k_d       = '0;
      grew_d    = 1'b0;
      started_d = 1'b0;
      count_d   = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      acc_q     <= '0;
      k_q       <= '0;
      started_q <= 1'b0;
      grew_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      rem_q     <= rem_d;
      acc_q     <= acc_d;
      k_q       <= k_d;
      started_q <= started_d;
      grew_q    <= grew_d;
      count_q   <= count_d;
    end
  end

  assign rem_zero = (rem_q == '0);

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_empty) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_mask_q  <= VMASK_W'(acc_q);
      out_idx_q   <= count_q[CIDX_W-1:0];
      out_cnt_q   <= rem_zero ? (count_q + CNT_W'(1)) : '0;
      out_empty_q <= 1'b0;
      out_last_q  <= rem_zero;
    end else if (cmd_i.emit_empty) begin
      out_mask_q  <= '0;
      out_idx_q   <= '0;
      out_cnt_q   <= '0;
      out_empty_q <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign component_mask_o  = out_mask_q;
  assign component_index_o = out_idx_q;
  assign component_count_o = out_cnt_q;
  assign empty_res_o       = out_empty_q;
  assign last_o            = out_last_q;

  assign sts_o.rem_zero = rem_zero;
  assign sts_o.k_last   = (CNT_W'(k_q) == (scan - CNT_W'(1)));
  assign sts_o.grew     = grew_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/core/hypergraph_connected_components.sv
// channel  direction  handshake              word
// in       input      in_valid_i/in_stall_o  func, edge_index, vertex_mask, edge_valid, edge_weight
// out      output     out_valid_o/out_stall_i component_mask, component_index, component_count,
//                                            empty_res, last
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load word is taken in the idle state without stalling the input; a compute word scans
// the edge store through one read port, reading a slot in ST_RD and testing it in ST_EVAL,
// with ST_PEND after each pass, repeating the pass until the component stops growing, and
// emits one result word per component, or a single empty word when nothing takes part
// rst_ni clears the active flags, the search state and the result valid
// the input stalls for the whole compute run; a stalled result word holds the search

module hypergraph_connected_components
  import hcc_pkg::*;
#(
  parameter int unsigned MAX_EDGES = 64,
  parameter int unsigned MAX_VERTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [SLOT_W-1:0]     edge_index_i,
  input  logic [VMASK_W-1:0]    vertex_mask_i,
  input  logic                  edge_valid_i,
  input  logic [WEIGHT_W-1:0]   edge_weight_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VMASK_W-1:0]    component_mask_o,
  output logic [CIDX_W-1:0]     component_index_o,
  output logic [CNT_W-1:0]      component_count_o,
  output logic                  empty_res_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  hcc_cmd_t cmd;
  hcc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  hcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hcc_dp #(
    .MAX_EDGES (MAX_EDGES),
    .MAX_VERTS (MAX_VERTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .edge_index_i      (edge_index_i),
    .vertex_mask_i     (vertex_mask_i),
    .edge_valid_i      (edge_valid_i),
    .edge_weight_i     (edge_weight_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .component_mask_o  (component_mask_o),
    .component_index_o (component_index_o),
    .component_count_o (component_count_o),
    .empty_res_o       (empty_res_o),
    .last_o            (last_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

FILE: tb/hcc_component_monitor.sv
module hcc_component_monitor
  import hcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  func_i,
  input  logic [SLOT_W-1:0]     edge_index_i,
  input  logic [VMASK_W-1:0]    vertex_mask_i,
  input  logic                  edge_valid_i,
  input  logic [WEIGHT_W-1:0]   edge_weight_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [VMASK_W-1:0]    component_mask_i,
  input  logic [CIDX_W-1:0]     component_index_i,
  input  logic [CNT_W-1:0]      component_count_i,
  input  logic                  empty_res_i,
  input  logic                  last_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VMASK_W-1:0] mask;
    logic [CIDX_W-1:0]  index;
    logic [CNT_W-1:0]   count;
    logic               no_comp;
    logic               is_last;
  } comp_word_t;

  logic [VMASK_W-1:0]  members [64];
  logic [63:0]         active_slots;
  logic [WEIGHT_W-1:0] threshold;
  logic [CNT_W-1:0]    scan_len;
  comp_word_t          expected_components [$];

  // flood fill over the active slots, seeded from the lowest remaining slot
  function automatic void split_components();
    logic [63:0]        remaining;
    logic [VMASK_W-1:0] visited, acc, fresh;
    logic [VMASK_W-1:0] masks [64];
    int unsigned        scan, found, seed;
    bit                 grew;
    comp_word_t         w;
    scan = (scan_len > 7'd64) ? 64 : scan_len;
    remaining = '0;
    for (int k = 0; k < scan; k++) begin
      if (active_slots[k]) remaining[k] = 1'b1;
    end
    visited = '0;
    found = 0;
    while (remaining != '0 && found < 64) begin
      seed = 0;
      while (!remaining[seed]) seed++;
      remaining[seed] = 1'b0;
      acc = members[seed] & ~visited;
      visited |= acc;
      do begin
        grew = 1'b0;
        for (int k = 0; k < scan; k++) begin
          if (remaining[k] && (members[k] & acc) != '0) begin
            remaining[k] = 1'b0;
            fresh = members[k] & ~visited;
            if (fresh != '0) begin
              visited |= fresh;
              acc |= fresh;
              grew = 1'b1;
            end
          end
        end
      end while (grew);
      masks[found] = acc;
      found++;
    end
    if (found == 0) begin
      w = '{mask: '0, index: '0, count: '0, no_comp: 1'b1, is_last: 1'b1};
      expected_components.push_back(w);
    end else begin
      for (int i = 0; i < found; i++) begin
        w.mask = masks[i];
        w.index = CIDX_W'(i);
        w.count = (i == found - 1) ? CNT_W'(found) : '0;
        w.no_comp = 1'b0;
        w.is_last = (i == found - 1);
        expected_components.push_back(w);
      end
    end
  endfunction

  function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    comp_word_t w;
    int         bad;
    if (!rst_ni) begin
      active_slots = '0;
      threshold = '0;
      scan_len = EDGES_IN_USE_RST;
      expected_components.delete();
      pending_o = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WEIGHT_THRESHOLD) threshold = cfg_data_i[WEIGHT_W-1:0];
        else if (cfg_index_i == CFG_EDGES_IN_USE) scan_len = cfg_data_i[CNT_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FUNC_LOAD) begin
          members[edge_index_i] = vertex_mask_i;
          active_slots[edge_index_i] = edge_valid_i && (edge_weight_i > threshold);
        end else begin
          split_components();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_components.size() == 0) begin
          $display("%0t unexpected result word: expected none, actual mask %0h",
                   $time, component_mask_i);
          mismatches_o++;
        end else begin
          w = expected_components.pop_front();
          bad = field_differs("component_mask", w.mask, component_mask_i)
              + field_differs("component_index", 64'(w.index), 64'(component_index_i))
              + field_differs("component_count", 64'(w.count), 64'(component_count_i))
              + field_differs("empty_res", 64'(w.no_comp), 64'(empty_res_i))
              + field_differs("last", 64'(w.is_last), 64'(last_i));
          if (bad != 0) mismatches_o++;
        end
      end
      pending_o = expected_components.size();
    end
  end

endmodule

FILE: tb/hypergraph_connected_components_tb.sv
module hypergraph_connected_components_tb;
  import hcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 24;

  localparam int IDLE_PCT  [4] = '{0, 45, 0, 25};
  localparam int STALL_PCT [4] = '{0, 0, 45, 25};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [SLOT_W-1:0]     edge_index_i;
  logic [VMASK_W-1:0]    vertex_mask_i;
  logic                  edge_valid_i;
  logic [WEIGHT_W-1:0]   edge_weight_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [VMASK_W-1:0]    component_mask_o;
  logic [CIDX_W-1:0]     component_index_o;
  logic [CNT_W-1:0]      component_count_o;
  logic                  empty_res_o;
  logic                  last_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                    pending;
  int                    mismatches;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;
  logic [WEIGHT_W-1:0]   cur_threshold = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hypergraph_connected_components u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .edge_index_i      (edge_index_i),
    .vertex_mask_i     (vertex_mask_i),
    .edge_valid_i      (edge_valid_i),
    .edge_weight_i     (edge_weight_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .component_mask_o  (component_mask_o),
    .component_index_o (component_index_o),
    .component_count_o (component_count_o),
    .empty_res_o       (empty_res_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  hcc_component_monitor u_monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .func_i            (func_i),
    .edge_index_i      (edge_index_i),
    .vertex_mask_i     (vertex_mask_i),
    .edge_valid_i      (edge_valid_i),
    .edge_weight_i     (edge_weight_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .component_mask_i  (component_mask_o),
    .component_index_i (component_index_o),
    .component_count_i (component_count_o),
    .empty_res_i       (empty_res_o),
    .last_i            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pending_o         (pending),
    .mismatches_o      (mismatches)
  );

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // no word moved on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(input logic f, input logic [SLOT_W-1:0] slot,
                           input logic [VMASK_W-1:0] mask, input logic ok,
                           input logic [WEIGHT_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    edge_index_i  <= slot;
    vertex_mask_i <= mask;
    edge_valid_i  <= ok;
    edge_weight_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_edge(input logic [SLOT_W-1:0] slot, input logic [VMASK_W-1:0] mask,
                           input logic ok, input logic [WEIGHT_W-1:0] w);
    send_word(FUNC_LOAD, slot, mask, ok, w);
  endtask

  task automatic run_compute();
    send_word(FUNC_COMPUTE, SLOT_W'($urandom), {$urandom, $urandom}, 1'($urandom),
              WEIGHT_W'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [WEIGHT_W-1:0] thr, input logic [CNT_W-1:0] scan);
    settle();
    write_reg(CFG_WEIGHT_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_EDGES_IN_USE, CFG_DATA_W'(scan));
    cfg_valid_i <= 1'b0;
    cur_threshold = thr;
  endtask

  // small vertex clusters so that edges overlap into several components
  function automatic logic [VMASK_W-1:0] pick_vertices();
    logic [VMASK_W-1:0] m;
    int unsigned        base;
    m = '0;
    case ($urandom_range(11))
      0: m = '0;
      1: m = {$urandom, $urandom};
      2: m[$urandom_range(63)] = 1'b1;
      default: begin
        base = $urandom_range(7) * 8;
        repeat ($urandom_range(1, 3)) m[(base + $urandom_range(9)) % 64] = 1'b1;
      end
    endcase
    return m;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(6))
      0: return cur_threshold;
      1: return (cur_threshold < 17'd65536) ? cur_threshold + WEIGHT_W'(1) : cur_threshold;
      2: return 17'd65536;
      3: return '0;
      4: return WEIGHT_W'($urandom_range(65536));
      default: return WEIGHT_W'($urandom_range(65536, cur_threshold));
    endcase
  endfunction

  initial begin
    int unsigned         sent, n, scan;
    logic [WEIGHT_W-1:0] thr;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_LOAD;
    edge_index_i  = '0;
    vertex_mask_i = '0;
    edge_valid_i  = 1'b0;
    edge_weight_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WEIGHT_THRESHOLD;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing active after reset
    run_compute();
    configure(17'd0, 7'd64);
    load_edge(6'd0, '1, 1'b1, 17'd65536);
    load_edge(6'd63, '0, 1'b1, 17'd1);
    load_edge(6'd1, 64'h8000_0000_0000_0000, 1'b1, 17'd0);
    load_edge(6'd2, 64'h5555_5555_5555_5555, 1'b0, 17'd65536);
    run_compute();
    run_compute();
    // chain that needs a second pass to close
    load_edge(6'd0, '1, 1'b0, 17'd65536);
    load_edge(6'd3, 64'h3, 1'b1, 17'd40000);
    load_edge(6'd9, 64'hC, 1'b1, 17'd40000);
    load_edge(6'd12, 64'h6, 1'b1, 17'd40000);
    run_compute();
    configure(17'd65536, 7'd64);
    load_edge(6'd5, 64'hF0, 1'b1, 17'd65536);
    run_compute();
    configure(17'd100, 7'd127);
    load_edge(6'd6, 64'h100, 1'b1, 17'd100);
    load_edge(6'd7, 64'h300, 1'b1, 17'd101);
    run_compute();
    configure(17'd100, 7'd0);
    run_compute();
    configure(17'd100, 7'd1);
    run_compute();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = '0;
        5: thr = 17'd65536;
        default: thr = ($urandom_range(2) == 0) ? '0 : WEIGHT_W'($urandom_range(50000));
      endcase
      scan = (p % 4 == 3) ? 64 : $urandom_range(16, 4);
      configure(thr, CNT_W'(scan));
      idle_pct  = IDLE_PCT[p % 4];
      stall_pct = STALL_PCT[p % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = $urandom_range(8, 1);
        repeat (n) begin
          load_edge(($urandom_range(6) == 0) ? SLOT_W'($urandom_range(63))
                                             : SLOT_W'($urandom_range(scan - 1)),
                    pick_vertices(), ($urandom_range(9) != 0), pick_weight());
        end
        run_compute();
        if ($urandom_range(7) == 0) begin
          run_compute();
          sent++;
        end
        sent += n + 1;
      end
    end

    idle_pct = 0;
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: hypergraph_connected_components.f
rtl/core/hcc_pkg.sv
rtl/core/hcc_ctrl.sv
rtl/core/hcc_dp.sv
rtl/core/hypergraph_connected_components.sv
tb/hcc_component_monitor.sv
tb/hypergraph_connected_components_tb.sv
